// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

    // Capacity of the deque and the widths that follow from it.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;

    // Field widths of the input and result beats.
    localparam int CMD_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int STATUS_W    = 2;
    localparam int OP_W        = 2;

    localparam int S_FIELDS_W  = CMD_W + VALUE_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = VALUE_W + COUNT_OUT_W + STATUS_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    // Operation codes: the upper two bits of cmd, the lowest bit picks the right end.
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_EDIT = 2'd2;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd3;

    // Status codes of a result beat.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic issue;     // execute the accepted command against the store
        logic load_out;  // move the finished result into the output register
    } deq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register is empty or is being drained this cycle
    } deq_stat_t;

endpackage

// ===== hw/rtl/deq_ram.sv =====
module deq_ram #(
    parameter int DATA_W    = 32,
    parameter int NUM_WORDS = 64
) (
    input  logic                         aclk,
    input  logic                         re,
    input  logic                         we,
    input  logic [$clog2(NUM_WORDS)-1:0] addr,
    input  logic [DATA_W-1:0]            wdata,
    output logic [DATA_W-1:0]            rdata
);

    logic [DATA_W-1:0] mem [NUM_WORDS];

    // Single port, read-first: the old word comes out while a new one is written.
    // The read data register holds its word until the next enabled read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[addr];
        end
        if (we) begin
            mem[addr] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
module deq_ctrl
    import deq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  deq_stat_t stat_i,
    output deq_cmd_t  cmd_o
);

    localparam logic [0:0] ST_IDLE   = 1'b0;
    localparam logic [0:0] ST_RESULT = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;

    // A command is taken only in idle; its registered read data is awaited in the result state.
    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd_o.issue    = 1'b0;
        cmd_o.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd_o.issue = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                cmd_o.load_out = stat_i.out_free;
                if (stat_i.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_issue_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.issue |=> (state_reg == ST_RESULT))
        else $error("accepted command did not move to result state");

    a_no_issue_in_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) |-> (!s_tready && !cmd_o.issue))
        else $error("command accepted while a result is pending");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RESULT) && !stat_i.out_free) |=> (state_reg == ST_RESULT))
        else $error("result state left while output register was full");
`endif

endmodule

// ===== hw/rtl/deq_datapath.sv =====
module deq_datapath
    import deq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  deq_cmd_t                  cmd_i,
    output deq_stat_t                 stat_o,
    input  logic [CMD_W-1:0]          in_cmd,
    input  logic signed [VALUE_W-1:0] in_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] out_value,
    output logic [COUNT_OUT_W-1:0]    out_count,
    output logic [STATUS_W-1:0]       out_status
);

    logic [ADDR_W-1:0]   head_reg;
    logic [ADDR_W-1:0]   head_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [STATUS_W-1:0] hold_status_reg;
    logic [STATUS_W-1:0] hold_status_next;
    logic                hold_take_reg;
    logic                hold_take_next;

    logic                       out_valid_reg;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic [COUNT_OUT_W-1:0]     out_count_reg;
    logic [STATUS_W-1:0]        out_status_reg;

    logic [OP_W-1:0]   op;
    logic              right;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] off_cnt;
    logic [ADDR_W-1:0] off_last;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W-1:0] right_push;
    logic [ADDR_W-1:0] right_end;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [VALUE_W-1:0] ram_rdata;

    // Ring index: head plus an offset below DEPTH, wrapped by one compare and subtract.
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Decode of the incoming command and the end positions.
    assign op         = in_cmd[CMD_W-1:1];
    assign right      = in_cmd[0];
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign off_cnt    = count_reg[ADDR_W-1:0];
    assign off_last   = off_cnt - 1'b1;
    assign head_dec   = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc   = wrap_add(head_reg, ADDR_W'(1));
    assign right_push = wrap_add(head_reg, off_cnt);
    assign right_end  = wrap_add(head_reg, off_last);

    // Command execution: store access plus head and count update in the accept cycle.
    always_comb begin
        ram_we           = 1'b0;
        ram_addr         = right ? right_end : head_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        hold_status_next = hold_status_reg;
        hold_take_next   = hold_take_reg;
        if (cmd_i.issue) begin
            hold_status_next = STAT_OK;
            hold_take_next   = 1'b0;
            case (op)
                OP_PUSH: begin
                    ram_addr = right ? right_push : head_dec;
                    if (full) begin
                        hold_status_next = STAT_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (!right) begin
                            head_next = head_dec;
                        end
                    end
                end
                OP_POP: begin
                    if (empty) begin
                        hold_status_next = STAT_EMPTY;
                    end else begin
                        hold_take_next = 1'b1;
                        count_next     = count_reg - 1'b1;
                        if (!right) begin
                            head_next = head_inc;
                        end
                    end
                end
                OP_EDIT: begin
                    if (empty) begin
                        hold_status_next = STAT_EMPTY;
                    end else begin
                        hold_take_next = 1'b1;
                        ram_we         = 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (empty) begin
                        hold_status_next = STAT_EMPTY;
                    end else begin
                        hold_take_next = 1'b1;
                    end
                end
                default: begin
                    hold_status_next = STAT_OK;
                end
            endcase
        end
    end

    // The store is read only for an accepted command, so its read data stays put
    // while the result waits for the output register.
    deq_ram #(
        .DATA_W    (VALUE_W),
        .NUM_WORDS (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .re    (cmd_i.issue),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_value),
        .rdata (ram_rdata)
    );

    // Pointer and count state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Per-command status held until the read data is back.
    always_ff @(posedge aclk) begin
        hold_status_reg <= hold_status_next;
        hold_take_reg   <= hold_take_next;
    end

    // Output register: valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd_i.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: result payload.
    always_ff @(posedge aclk) begin
        if (cmd_i.load_out) begin
            out_value_reg  <= hold_take_reg ? ram_rdata : '0;
            out_count_reg  <= COUNT_OUT_W'(count_reg);
            out_status_reg <= hold_status_reg;
        end
    end

    assign stat_o.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_value       = out_value_reg;
    assign out_count       = out_count_reg;
    assign out_status      = out_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("count exceeds capacity");

    a_full_push_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.issue && (op == OP_PUSH) && full) |=> ($stable(count_reg) && $stable(head_reg)))
        else $error("push into a full deque changed the state");

    a_pop_decrements: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.issue && (op == OP_POP) && !empty) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not decrement the count");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.load_out |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// Bounded double-ended queue of DEPTH (64) signed 32-bit words held in a single-port ring
// memory with a head pointer and a count. Each input beat carries a command (push, pop,
// edit or peek, at the left or right end) and a value; each produces exactly one result
// beat with the word read (zero for pushes and errors), the count after the command and
// a status (ok, empty, or full). Errors leave the deque unchanged. For each command the
// store is read and written in the accept cycle, and its registered read data is moved
// into the output register once that register is free, so a new command is accepted only
// after the previous result has been loaded. The output register lets the next command be
// accepted while the previous result still waits on m_tready.
module double_ended_queue_top
    import deq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Fields from bit 0 up: cmd[2:0], value[34:3], zero padding.
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0 up: value_out[31:0], count_out[38:32], status[40:39], zero padding.
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    deq_cmd_t                  cmd;
    deq_stat_t                 stat;
    logic [CMD_W-1:0]          in_cmd;
    logic signed [VALUE_W-1:0] in_value;
    logic signed [VALUE_W-1:0] value_out;
    logic [COUNT_OUT_W-1:0]    count_out;
    logic [STATUS_W-1:0]       status;

    // Unpack the input beat.
    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_value = s_tdata[CMD_W +: VALUE_W];

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    deq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_i      (cmd),
        .stat_o     (stat),
        .in_cmd     (in_cmd),
        .in_value   (in_value),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (value_out),
        .out_count  (count_out),
        .out_status (status)
    );

    // Pack the result beat.
    assign m_tdata = {{M_PAD_W{1'b0}}, status, count_out, value_out};

endmodule
